/* sv/okvt_pkg.sv */
package okvt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } fsm_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] found_value;
  } out_t;

endpackage

/* sv/okvt_ram.sv */
module okvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/ordered_key_value_table.sv */
// Channel   Handshake            Payload                     Notes
// input     start & !busy        in_data (okvt_pkg::in_t)    one request per beat
// result    out_valid            out_data (okvt_pkg::out_t)  one result per request
//
// Flow: insert, the unused request code and a search or remove on an empty
// table register their result beat at the accepting edge. Search and remove
// issue one read of the key/value memories per cycle, newest entry first,
// stopping at a hit or after the oldest entry. A remove then moves each entry
// newer than the hit down by one slot through the same read/write ports.
// Reset: synchronous, active low; clears the entry count and the controller.
// The memories are not cleared: only entries below the count are ever read.
// Stalls: busy holds off new requests while a scan or shift runs. The
// receiver cannot stall: a result shows for exactly one cycle.
module ordered_key_value_table #(
  parameter int DEPTH = okvt_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  okvt_pkg::in_t  in_data,
  output logic           out_valid,
  output okvt_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  okvt_pkg::fsm_t state_r, state_nxt;
  logic [1:0]                      req_r, req_nxt;
  logic [okvt_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [AW-1:0]                   ptr_r, ptr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  okvt_pkg::out_t                  out_r, out_nxt;

  // memory ports
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [AW-1:0]                   raddr;
  logic [okvt_pkg::KEY_W-1:0]      wkey;
  logic [okvt_pkg::VAL_W-1:0]      wval;
  logic [okvt_pkg::KEY_W-1:0]      rd_key;
  logic [okvt_pkg::VAL_W-1:0]      rd_val;

  logic [CW-1:0]                   cnt_m1;
  logic [AW-1:0]                   last_idx;
  logic                            hit;

  assign cnt_m1   = cnt_r - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign hit      = (rd_key == key_r);

  okvt_ram #(
    .WIDTH (okvt_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rd_key)
  );

  okvt_ram #(
    .WIDTH (okvt_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rd_val)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = ptr_r - AW'(1);
    wkey          = rd_key;
    wval          = rd_val;
    raddr         = ptr_r - AW'(1);

    case (state_r)
      okvt_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_data.req_type;
          key_nxt = in_data.lookup_key;
          case (in_data.req_type)
            okvt_pkg::REQ_INSERT: begin
              out_valid_nxt       = 1'b1;
              out_nxt.found_value = '0;
              if (cnt_r == CW'(DEPTH)) begin
                out_nxt.status = okvt_pkg::STAT_FULL;
              end else begin
                // append at the newest end
                we             = 1'b1;
                waddr          = cnt_r[AW-1:0];
                wkey           = in_data.lookup_key;
                wval           = in_data.entry_value;
                cnt_nxt        = cnt_r + CW'(1);
                out_nxt.status = okvt_pkg::STAT_DONE;
              end
            end
            okvt_pkg::REQ_SEARCH, okvt_pkg::REQ_REMOVE: begin
              if (cnt_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_nxt.status      = okvt_pkg::STAT_MISSING;
                out_nxt.found_value = '0;
              end else begin
                // start the scan at the newest entry
                raddr     = last_idx;
                ptr_nxt   = last_idx;
                state_nxt = okvt_pkg::S_SCAN;
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_nxt.status      = okvt_pkg::STAT_DONE;
              out_nxt.found_value = '0;
            end
          endcase
        end
      end

      okvt_pkg::S_SCAN: begin
        // rd_key/rd_val hold the entry at ptr_r
        if (hit) begin
          if (req_r == okvt_pkg::REQ_SEARCH) begin
            out_valid_nxt       = 1'b1;
            out_nxt.status      = okvt_pkg::STAT_DONE;
            out_nxt.found_value = rd_val;
            state_nxt           = okvt_pkg::S_IDLE;
          end else if (ptr_r == last_idx) begin
            cnt_nxt             = cnt_m1;
            out_valid_nxt       = 1'b1;
            out_nxt.status      = okvt_pkg::STAT_DONE;
            out_nxt.found_value = '0;
            state_nxt           = okvt_pkg::S_IDLE;
          end else begin
            // close the gap: fetch the next newer entry
            raddr     = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = okvt_pkg::S_SHIFT;
          end
        end else if (ptr_r == '0) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = okvt_pkg::STAT_MISSING;
          out_nxt.found_value = '0;
          state_nxt           = okvt_pkg::S_IDLE;
        end else begin
          ptr_nxt = ptr_r - AW'(1);
        end
      end

      okvt_pkg::S_SHIFT: begin
        // move the entry at ptr_r down one slot
        we = 1'b1;
        if (ptr_r == last_idx) begin
          cnt_nxt             = cnt_m1;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = okvt_pkg::STAT_DONE;
          out_nxt.found_value = '0;
          state_nxt           = okvt_pkg::S_IDLE;
        end else begin
          raddr   = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      default: begin
        state_nxt = okvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okvt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    key_r <= key_nxt;
    ptr_r <= ptr_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != okvt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result beat while a scan is still running");

  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && cnt_r != '0 &&
     (in_data.req_type == okvt_pkg::REQ_SEARCH ||
      in_data.req_type == okvt_pkg::REQ_REMOVE)) |=> busy)
    else $error("search or remove did not start a scan");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == okvt_pkg::REQ_INSERT &&
     cnt_r != CW'(DEPTH)) |=> (cnt_r == $past(cnt_r) + CW'(1)) && out_valid_r)
    else $error("insert did not grow the table");

  a_shift_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == okvt_pkg::S_SHIFT) |-> (ptr_r != '0 && ptr_r <= last_idx))
    else $error("shift pointer outside the held entries");
`endif

endmodule
